>>> rtl/chr_pkg.sv
// Shared types and codes for the command history ring.
`default_nettype none
package chr_pkg;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_NEXT = 2'd1;
	localparam logic [1:0] KIND_PREV = 2'd2;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_END,
		OP_NEXT,
		OP_PREV
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage
`default_nettype wire

>>> rtl/chr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

>>> rtl/chr_front.sv
// Front end: accepts input items, classifies them and queues commands.
`default_nettype none
module chr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [1:0]          kind,
	input  wire  [7:0]          char_in,
	output chr_pkg::cmd_chan_t  deq,
	input  wire                 deq_take
);

	chr_pkg::cmd_t q_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	chr_pkg::cmd_t cls;
	logic          known;
	logic          push;
	logic          pop;

	always_comb begin
		cls.ch = char_in;
		cls.op = chr_pkg::OP_CHAR;
		known  = 1'b1;
		case (kind)
			chr_pkg::KIND_PUSH: begin
				cls.op = (char_in == 8'd0) ? chr_pkg::OP_END : chr_pkg::OP_CHAR;
			end
			chr_pkg::KIND_NEXT: cls.op = chr_pkg::OP_NEXT;
			chr_pkg::KIND_PREV: cls.op = chr_pkg::OP_PREV;
			default:            known = 1'b0;
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall && known;
	assign deq.valid = (cnt_q != 2'd0);
	assign deq.cmd   = q_q[rd_ptr_q];
	assign pop       = deq.valid && deq_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

>>> rtl/chr_back.sv
// Back end: staging line, duplicate check, ring store and entry streaming.
`default_nettype none
module chr_back #(
	parameter int HISTORY_DEPTH = 8,
	parameter int LINE_CHARS    = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire chr_pkg::cmd_chan_t deq,
	output logic                deq_take,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [7:0]          char_out,
	output logic                last,
	output logic                list_empty,
	output logic                stored
);

	localparam int SW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW   = $clog2(LINE_CHARS);
	localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
	localparam int AW   = SW + CW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CFILL,
		S_CMP,
		S_CPFILL,
		S_COPY,
		S_SFILL,
		S_SOUT,
		S_RESP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   len_q;
	logic [SW-1:0]   newest_q;
	logic [SW-1:0]   view_q;
	logic [SW-1:0]   slot_q;
	logic [CNTW-1:0] count_q;
	logic            match_q;
	logic            res_empty_q;
	logic            res_stored_q;
	logic            out_valid_q;
	logic [7:0]      char_q;
	logic            last_q;
	logic            empty_q;
	logic            stored_q;

	logic [CW-1:0]   idx_inc;
	logic [CW-1:0]   rd_idx;
	logic            idx_adv;
	logic            out_free;
	logic            out_load;
	logic            s_end;
	logic            mism;
	logic [SW-1:0]   newest_next;
	logic [SW-1:0]   view_next;
	logic [SW-1:0]   prev_slot;
	logic [CNTW-1:0] cnt_m1;
	logic [SW-1:0]   ent_slot;
	logic            ent_wr_en;
	logic [7:0]      ent_wr_data;
	logic [7:0]      ent_rd;
	logic            stg_wr_en;
	logic [7:0]      stg_rd;

	assign out_free    = !out_valid_q || !out_stall;
	assign out_load    = out_free && (state_q == S_SOUT || state_q == S_RESP);
	assign idx_inc     = idx_q + CW'(1);
	assign s_end       = (ent_rd == 8'd0) || (idx_q == CW'(LINE_CHARS - 1));
	assign mism        = (idx_q == len_q) ? (ent_rd != 8'd0) : (ent_rd != stg_rd);
	assign newest_next = (newest_q == SW'(HISTORY_DEPTH - 1)) ? '0 : newest_q + SW'(1);
	assign cnt_m1      = count_q - CNTW'(1);
	assign view_next   = (CNTW'(view_q) + CNTW'(1) >= count_q) ? '0 : view_q + SW'(1);
	assign prev_slot   = (CNTW'(view_q) >= count_q) ? cnt_m1[SW-1:0] : view_q;
	assign deq_take    = (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_CMP, S_COPY: idx_adv = (idx_q != len_q);
			S_SOUT:        idx_adv = out_free && !s_end;
			default:       idx_adv = 1'b0;
		endcase
	end

	assign rd_idx      = idx_adv ? idx_inc : idx_q;
	assign ent_slot    = (state_q == S_CFILL || state_q == S_CMP) ? newest_q : slot_q;
	assign ent_wr_en   = (state_q == S_COPY);
	assign ent_wr_data = (idx_q == len_q) ? 8'd0 : stg_rd;
	assign stg_wr_en   = (state_q == S_IDLE) && deq.valid && (deq.cmd.op == chr_pkg::OP_CHAR)
		&& (len_q < CW'(LINE_CHARS - 1));

	chr_ram #(
		.WIDTH(8),
		.DEPTH(1 << AW)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (ent_wr_en),
		.wr_addr({slot_q, idx_q}),
		.wr_data(ent_wr_data),
		.rd_addr({ent_slot, rd_idx}),
		.rd_data(ent_rd)
	);

	chr_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CHARS)
	) u_staging_ram (
		.clk    (clk),
		.wr_en  (stg_wr_en),
		.wr_addr(len_q),
		.wr_data(deq.cmd.ch),
		.rd_addr(rd_idx),
		.rd_data(stg_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			len_q        <= '0;
			newest_q     <= SW'(HISTORY_DEPTH - 1);
			view_q       <= '0;
			slot_q       <= '0;
			count_q      <= '0;
			match_q      <= 1'b0;
			res_empty_q  <= 1'b0;
			res_stored_q <= 1'b0;
			out_valid_q  <= 1'b0;
			char_q       <= 8'd0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
			stored_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (deq.valid) begin
						idx_q        <= '0;
						match_q      <= 1'b1;
						res_empty_q  <= 1'b0;
						res_stored_q <= 1'b0;
						case (deq.cmd.op)
							chr_pkg::OP_CHAR: begin
								if (stg_wr_en) begin
									len_q <= len_q + CW'(1);
								end
							end
							chr_pkg::OP_END: begin
								if (count_q == '0) begin
									slot_q  <= newest_next;
									state_q <= S_CPFILL;
								end else begin
									state_q <= S_CFILL;
								end
							end
							chr_pkg::OP_NEXT: begin
								if (count_q == '0) begin
									res_empty_q <= 1'b1;
									state_q     <= S_RESP;
								end else begin
									view_q  <= view_next;
									slot_q  <= view_next;
									state_q <= S_SFILL;
								end
							end
							default: begin
								if (count_q == '0) begin
									res_empty_q <= 1'b1;
									state_q     <= S_RESP;
								end else begin
									slot_q  <= prev_slot;
									view_q  <= (prev_slot == '0) ? cnt_m1[SW-1:0]
										: prev_slot - SW'(1);
									state_q <= S_SFILL;
								end
							end
						endcase
					end
				end
				S_CFILL: state_q <= S_CMP;
				S_CMP: begin
					if (idx_q == len_q) begin
						idx_q <= '0;
						if (match_q && !mism) begin
							view_q  <= newest_q;
							len_q   <= '0;
							state_q <= S_RESP;
						end else begin
							slot_q  <= newest_next;
							state_q <= S_CPFILL;
						end
					end else begin
						match_q <= match_q && !mism;
						idx_q   <= idx_inc;
					end
				end
				S_CPFILL: state_q <= S_COPY;
				S_COPY: begin
					if (idx_q == len_q) begin
						newest_q     <= slot_q;
						view_q       <= slot_q;
						len_q        <= '0;
						res_stored_q <= 1'b1;
						if (count_q != CNTW'(HISTORY_DEPTH)) begin
							count_q <= count_q + CNTW'(1);
						end
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SFILL: state_q <= S_SOUT;
				S_SOUT: begin
					if (out_free) begin
						char_q      <= s_end ? 8'd0 : ent_rd;
						last_q      <= s_end;
						empty_q     <= 1'b0;
						stored_q    <= 1'b0;
						if (s_end) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						char_q      <= 8'd0;
						last_q      <= 1'b1;
						empty_q     <= res_empty_q;
						stored_q    <= res_stored_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign char_out   = char_q;
	assign last       = last_q;
	assign list_empty = empty_q;
	assign stored     = stored_q;

endmodule
`default_nettype wire

>>> rtl/command_history_ring.sv
// Command history ring: top level joining the command front end and the executing back end.
// Push character: written to staging RAM from idle. Push end: compare walk against the
// newest entry, then copy if stored; a duplicate has no copy, an empty store no compare.
// Next/prev: after S_SFILL, one character per cycle from the entry RAM unless out_stall.
// A two-entry command queue lets input items be taken while the back end is streaming.
// Reset clears control state at once; entry and staging RAMs are not cleared.
`default_nettype none
module command_history_ring #(
	parameter int HISTORY_DEPTH = 8,
	parameter int LINE_CHARS    = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [1:0] kind,
	input  wire  [7:0] char_in,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] char_out,
	output logic       last,
	output logic       list_empty,
	output logic       stored
);

	chr_pkg::cmd_chan_t deq;
	logic               deq_take;

	chr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind    (kind),
		.char_in (char_in),
		.deq     (deq),
		.deq_take(deq_take)
	);

	chr_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.LINE_CHARS   (LINE_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq       (deq),
		.deq_take  (deq_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last      (last),
		.list_empty(list_empty),
		.stored    (stored)
	);

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for command_history_ring: directed and random command traffic checked by a scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HISTORY_DEPTH = 8;
	localparam int LINE_CHARS    = 32;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [7:0] CHAR_END  = 8'h00;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       empty;
		logic       stored;
	} line_char_t;

	class history_scoreboard;
		logic [7:0] lines [HISTORY_DEPTH][LINE_CHARS];
		logic [7:0] staging [LINE_CHARS];
		int stage_len;
		int newest;
		int count;
		int view;
		line_char_t expected_chars[$];
		int errors;

		function new();
			foreach (lines[s, c]) lines[s][c] = CHAR_END;
			foreach (staging[c]) staging[c] = CHAR_END;
			stage_len = 0;
			newest = HISTORY_DEPTH - 1;
			count = 0;
			view = 0;
			errors = 0;
		endfunction

		function void add_expected(logic [7:0] ch, logic lst, logic emp, logic sto);
			line_char_t e;
			e.ch = ch;
			e.last = lst;
			e.empty = emp;
			e.stored = sto;
			expected_chars.push_back(e);
		endfunction

		function void stream_line(int slot);
			int i;
			logic [7:0] ch;
			bit fin;
			for (i = 0; i < LINE_CHARS; i++) begin
				ch = lines[slot][i];
				fin = (ch == CHAR_END) || (i == LINE_CHARS - 1);
				add_expected(fin ? CHAR_END : ch, fin, 1'b0, 1'b0);
				if (fin)
					break;
			end
		endfunction

		function void note_command(logic [1:0] k, logic [7:0] c);
			bit same;
			int i;
			if (k == chr_pkg::KIND_PUSH) begin
				if (c != CHAR_END) begin
					if (stage_len < LINE_CHARS - 1) begin
						staging[stage_len] = c;
						stage_len++;
					end
					return;
				end
				same = (count != 0);
				for (i = 0; i < stage_len && same; i++)
					if (lines[newest][i] != staging[i])
						same = 1'b0;
				if (same && lines[newest][stage_len] != CHAR_END)
					same = 1'b0;
				if (!same) begin
					newest = (newest + 1 >= HISTORY_DEPTH) ? 0 : newest + 1;
					for (i = 0; i < stage_len; i++)
						lines[newest][i] = staging[i];
					lines[newest][stage_len] = CHAR_END;
					if (count < HISTORY_DEPTH)
						count++;
				end
				view = newest;
				stage_len = 0;
				add_expected(CHAR_END, 1'b1, 1'b0, !same);
			end else if (k == chr_pkg::KIND_NEXT || k == chr_pkg::KIND_PREV) begin
				if (count == 0) begin
					add_expected(CHAR_END, 1'b1, 1'b1, 1'b0);
					return;
				end
				if (k == chr_pkg::KIND_NEXT) begin
					view = (view + 1 >= count) ? 0 : view + 1;
					stream_line(view);
				end else begin
					if (view >= count)
						view = count - 1;
					stream_line(view);
					view = (view == 0) ? count - 1 : view - 1;
				end
			end
		endfunction

		function void check_char(logic [7:0] ch, logic lst, logic emp, logic sto);
			line_char_t e;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected result char_out=%h last=%b list_empty=%b stored=%b",
					$time, ch, lst, emp, sto);
				errors++;
				return;
			end
			e = expected_chars.pop_front();
			if (ch !== e.ch) begin
				$display("%0t: char_out expected %h got %h", $time, e.ch, ch);
				errors++;
			end
			if (lst !== e.last) begin
				$display("%0t: last expected %b got %b", $time, e.last, lst);
				errors++;
			end
			if (emp !== e.empty) begin
				$display("%0t: list_empty expected %b got %b", $time, e.empty, emp);
				errors++;
			end
			if (sto !== e.stored) begin
				$display("%0t: stored expected %b got %b", $time, e.stored, sto);
				errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] kind = chr_pkg::KIND_PUSH;
	logic [7:0] char_in = CHAR_END;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] char_out;
	logic       last;
	logic       list_empty;
	logic       stored;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	logic [7:0] last_command[$];
	history_scoreboard sb = new();

	command_history_ring #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.LINE_CHARS(LINE_CHARS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.last(last),
		.list_empty(list_empty),
		.stored(stored)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_char(char_out, last, list_empty, stored);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [7:0] c);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		char_in <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_command(k, c);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_char();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(8'h63, 8'h61));
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic run_random(input int n_items);
		int sent;
		int roll;
		int len;
		int n;
		int i;
		logic [7:0] cmd[$];
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				if (last_command.size() > 0 && $urandom_range(3) == 0) begin
					cmd = last_command;
				end else begin
					cmd = {};
					len = ($urandom_range(19) == 0) ? $urandom_range(40, 28) : $urandom_range(5, 0);
					for (i = 0; i < len; i++)
						cmd.push_back(random_char());
				end
				foreach (cmd[j])
					send_item(chr_pkg::KIND_PUSH, cmd[j]);
				send_item(chr_pkg::KIND_PUSH, CHAR_END);
				sent += cmd.size() + 1;
				last_command = cmd;
			end else if (roll < 90) begin
				n = $urandom_range(4, 1);
				for (i = 0; i < n; i++)
					send_item($urandom_range(1) ? chr_pkg::KIND_NEXT : chr_pkg::KIND_PREV,
						8'($urandom_range(255)));
				sent += n;
			end else if (roll < 95) begin
				send_item(KIND_NONE, 8'($urandom_range(255)));
				sent += 1;
			end else begin
				// partial line, then browsing before it is ended
				n = $urandom_range(3, 1);
				for (i = 0; i < n; i++)
					send_item(chr_pkg::KIND_PUSH, random_char());
				send_item($urandom_range(1) ? chr_pkg::KIND_NEXT : chr_pkg::KIND_PREV,
					8'($urandom_range(255)));
				sent += n + 1;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty store, ignored kind, empty and non-empty commands with duplicates, browsing
		send_item(chr_pkg::KIND_NEXT, 8'h00);
		send_item(chr_pkg::KIND_PREV, 8'hFF);
		send_item(KIND_NONE, 8'hA5);
		send_item(chr_pkg::KIND_PUSH, CHAR_END);
		send_item(chr_pkg::KIND_PUSH, CHAR_END);
		send_item(chr_pkg::KIND_NEXT, 8'hFF);
		send_item(chr_pkg::KIND_PUSH, 8'hFF);
		send_item(chr_pkg::KIND_PUSH, 8'h01);
		send_item(chr_pkg::KIND_PUSH, CHAR_END);
		send_item(chr_pkg::KIND_PUSH, 8'hFF);
		send_item(chr_pkg::KIND_PUSH, 8'h01);
		send_item(chr_pkg::KIND_PUSH, CHAR_END);
		send_item(chr_pkg::KIND_PUSH, 8'h80);
		send_item(chr_pkg::KIND_PUSH, 8'h7F);
		send_item(chr_pkg::KIND_PUSH, 8'h55);
		send_item(chr_pkg::KIND_PUSH, CHAR_END);
		send_item(chr_pkg::KIND_PREV, 8'h00);
		send_item(chr_pkg::KIND_PREV, 8'hAA);
		send_item(chr_pkg::KIND_PREV, 8'h55);
		send_item(chr_pkg::KIND_NEXT, 8'h00);
		send_item(KIND_NONE, 8'h00);
		send_item(chr_pkg::KIND_NEXT, 8'hFF);
		wait_drained();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_random(90);
		wait_drained();
		send_gap_pct = 48;
		recv_stall_pct = 0;
		run_random(90);
		wait_drained();
		send_gap_pct = 0;
		recv_stall_pct = 48;
		run_random(90);
		wait_drained();
		send_gap_pct = 12;
		recv_stall_pct = 12;
		run_random(90);
		wait_drained();

		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

>>> files.f
rtl/chr_pkg.sv
rtl/chr_ram.sv
rtl/chr_front.sv
rtl/chr_back.sv
rtl/command_history_ring.sv
dv/tb_top.sv
